@@ sv/scs_pkg.sv @@
// Shared constants, CORDIC angle table and word types for the spherical/Cartesian converter.
`timescale 1ns / 1ps

package scs_pkg;

  // Word geometry
  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned ANGLE_BITS = 32;
  localparam int unsigned DW         = 64;
  localparam int unsigned STEPS      = 30;
  localparam int unsigned LANES      = 2;
  localparam int unsigned MUL_LAT    = 3;
  localparam int unsigned GUARD      = 58 - COORD_BITS;

  typedef logic signed [DW-1:0] dw_t;
  typedef logic        [31:0]   turn_t;

  // CORDIC gain correction and unity, both Q30
  localparam logic signed [31:0] KQ30    = 32'sd652032874;
  localparam dw_t                ONE_Q30 = dw_t'(64'sd1073741824);

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn
  localparam turn_t ATAN_TURNS [STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // One CORDIC lane: vector, angle accumulator and mode (1 = vectoring)
  typedef struct packed {
    dw_t  x;
    dw_t  y;
    dw_t  z;
    logic vec;
  } lane_t;

  typedef struct packed {
    logic                         mode;
    logic        [ANGLE_BITS-1:0] ra_in;
    logic signed [ANGLE_BITS-1:0] dec_in;
    logic        [COORD_BITS-1:0] range_in;
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
    logic signed [COORD_BITS-1:0] z_in;
  } scs_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_out;
    logic signed [COORD_BITS-1:0] y_out;
    logic signed [COORD_BITS-1:0] z_out;
    logic        [ANGLE_BITS-1:0] ra_out;
    logic signed [ANGLE_BITS-1:0] dec_out;
    logic        [COORD_BITS-1:0] range_out;
  } scs_res_t;

endpackage

@@ sv/spherical_cartesian_convert_top.sv @@
// Top level of the spherical/Cartesian point converter: CORDIC cell chains and output stage.
`timescale 1ns / 1ps

// Usage:
//   Drive a point on req_i and raise start; it is taken at the rising edge
//   where start is high and busy is low. busy is always low, so a new point
//   may be taken in every cycle.
//   req_i.mode selects forward (spherical to Cartesian) or inverse conversion;
//   fields of the other mode are ignored, and unused result fields are zero.
//   Each result word appears on res_o for exactly one cycle with strobe_o high,
//   in the order taken.
//   Latency is set by the two 30-cell CORDIC chains (angle pass, then the
//   elevation pass), two pairs of 3-stage Q30 multipliers, one input stage, one
//   quadrant stage and the output register. Throughput is one point a cycle.
//   The receiver cannot stall: a result is lost if not taken in its cycle.
//   Reset clears every valid flag in the pipeline; points in flight are
//   dropped and no strobe follows until new points are taken.
module spherical_cartesian_convert_top import scs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  scs_req_t req_i,
  output logic     strobe_o,
  output scs_res_t res_o
);

  localparam logic MODE_FWD = 1'b0;
  localparam int unsigned LATENCY = 2 * STEPS + 2 * MUL_LAT + 3;
  localparam int unsigned UP   = ANGLE_BITS > 32 ? ANGLE_BITS - 32 : 0;
  localparam int unsigned DN   = ANGLE_BITS < 32 ? 32 - ANGLE_BITS : 0;
  localparam dw_t         HALF = DN > 0 ? dw_t'(64'sd1 <<< (DN - 1)) : dw_t'(0);
  localparam dw_t         K_DW = dw_t'(KQ30);
  localparam dw_t         CMAX = dw_t'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam dw_t         CMIN = -CMAX - dw_t'(1);
  localparam logic [DW-1:0] RMAX  = DW'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [DW-1:0] RND_G = DW'(64'd1 << (GUARD - 1));
  localparam dw_t         HALF_TURN = dw_t'(64'sd1 <<< 31);

  typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quad_e;

  // Per-point data that rides along the chains
  typedef struct packed {
    logic                    mode;
    quad_e                   qra;
    quad_e                   qdec;
    logic [COORD_BITS-1:0]   r;
    dw_t                     zc;
    logic                    xy_zero;
    logic                    xyz_zero;
    dw_t                     ang_a;
    logic signed [31:0]      ca;
    logic signed [31:0]      sa;
    dw_t                     rc;
    dw_t                     zr;
    dw_t                     d;
  } side_t;

  function automatic turn_t to_turns(logic [ANGLE_BITS-1:0] a);
    logic [63:0] t;
    t = 64'(a) >> UP;
    t = t << DN;
    return t[31:0];
  endfunction

  function automatic logic [ANGLE_BITS-1:0] from_turns(dw_t d);
    dw_t t;
    t = ((d + HALF) >>> DN) <<< UP;
    return t[ANGLE_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] clamp_q30(dw_t v);
    if (v > ONE_Q30) begin
      return ONE_Q30[31:0];
    end else if (v < -ONE_Q30) begin
      return 32'(-ONE_Q30);
    end
    return v[31:0];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_coord(dw_t v);
    if (v > CMAX) begin
      return CMAX[COORD_BITS-1:0];
    end else if (v < CMIN) begin
      return CMIN[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

  // Returns {cos, sin} after undoing the quadrant fold
  function automatic logic [63:0] quad_map(quad_e q, logic signed [31:0] x,
                                           logic signed [31:0] y);
    logic [63:0] cs;
    unique case (q)
      QUAD_0:   cs = {x, y};
      QUAD_90:  cs = {32'(-y), x};
      QUAD_180: cs = {32'(-x), 32'(-y)};
      QUAD_270: cs = {y, 32'(-x)};
    endcase
    return cs;
  endfunction

  assign busy = 1'b0;

  // ---------------- Input stage ----------------
  turn_t p_ra, p_dec, off_ra, off_dec, w_ra, w_dec;
  dw_t   sx, sy, sz, sxs, sys;
  logic  xneg;
  lane_t [LANES-1:0] lane0_d, lane0_q;
  side_t side0_d;
  logic  valid0_q;

  assign p_ra    = to_turns(req_i.ra_in);
  assign p_dec   = to_turns(req_i.dec_in);
  assign off_ra  = p_ra + 32'h2000_0000;
  assign off_dec = p_dec + 32'h2000_0000;
  assign w_ra    = p_ra - {off_ra[31:30], 30'd0};
  assign w_dec   = p_dec - {off_dec[31:30], 30'd0};

  assign sx   = {{(DW-COORD_BITS){req_i.x_in[COORD_BITS-1]}}, req_i.x_in};
  assign sy   = {{(DW-COORD_BITS){req_i.y_in[COORD_BITS-1]}}, req_i.y_in};
  assign sz   = {{(DW-COORD_BITS){req_i.z_in[COORD_BITS-1]}}, req_i.z_in};
  assign sxs  = sx <<< GUARD;
  assign sys  = sy <<< GUARD;
  assign xneg = sx[DW-1];

  // Seed the lanes: two rotations forward, one vectoring pass inverse
  always_comb begin
    lane0_d[1].x   = K_DW;
    lane0_d[1].y   = '0;
    lane0_d[1].z   = {{(DW-32){w_dec[31]}}, w_dec};
    lane0_d[1].vec = 1'b0;
    if (req_i.mode == MODE_FWD) begin
      lane0_d[0].x   = K_DW;
      lane0_d[0].y   = '0;
      lane0_d[0].z   = {{(DW-32){w_ra[31]}}, w_ra};
      lane0_d[0].vec = 1'b0;
    end else begin
      lane0_d[0].x   = xneg ? -sxs : sxs;
      lane0_d[0].y   = xneg ? -sys : sys;
      lane0_d[0].z   = xneg ? HALF_TURN : '0;
      lane0_d[0].vec = 1'b1;
    end
    side0_d          = '0;
    side0_d.mode     = req_i.mode;
    side0_d.qra      = quad_e'(off_ra[31:30]);
    side0_d.qdec     = quad_e'(off_dec[31:30]);
    side0_d.r        = req_i.range_in;
    side0_d.zc       = sz <<< GUARD;
    side0_d.xy_zero  = (req_i.x_in == '0) && (req_i.y_in == '0);
    side0_d.xyz_zero = side0_d.xy_zero && (req_i.z_in == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else begin
      valid0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    lane0_q <= lane0_d;
  end

  // ---------------- Chain A: sin/cos or planar angle ----------------
  logic              valid_a [STEPS+1];
  lane_t [LANES-1:0] lane_a  [STEPS+1];
  side_t             side_a  [STEPS+1];

  assign valid_a[0] = valid0_q;
  assign lane_a[0]  = lane0_q;

  for (genvar k = 0; k < STEPS; k++) begin : g_chain_a
    scs_cell #(.STEP(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_a[k]),
      .lane_i  (lane_a[k]),
      .valid_o (valid_a[k+1]),
      .lane_o  (lane_a[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    side_a[0] <= side0_d;
    for (int k = 1; k <= STEPS; k++) begin
      side_a[k] <= side_a[k-1];
    end
  end

  // ---------------- Quadrant stage ----------------
  logic [63:0]        cs_ra, cs_dec;
  logic               valid_q_q;
  side_t              side_q_d, side_q_q;
  dw_t                m1a_q, m2a_q;
  logic signed [31:0] m1c_q, m2c_q;
  dw_t                r_dw;

  assign cs_ra  = quad_map(side_a[STEPS].qra, clamp_q30(lane_a[STEPS][0].x),
                           clamp_q30(lane_a[STEPS][0].y));
  assign cs_dec = quad_map(side_a[STEPS].qdec, clamp_q30(lane_a[STEPS][1].x),
                           clamp_q30(lane_a[STEPS][1].y));
  assign r_dw   = dw_t'({{(DW-COORD_BITS){1'b0}}, side_a[STEPS].r});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q_q <= 1'b0;
    end else begin
      valid_q_q <= valid_a[STEPS];
    end
  end

  // Attach the longitude sine, cosine and planar angle to the side word
  always_comb begin
    side_q_d       = side_a[STEPS];
    side_q_d.ca    = cs_ra[63:32];
    side_q_d.sa    = cs_ra[31:0];
    side_q_d.ang_a = lane_a[STEPS][0].z;
  end

  // Pick multiplier operands: r*cos(dec), r*sin(dec) forward; gain removal inverse
  always_ff @(posedge clk_i) begin
    side_q_q <= side_q_d;
    m1a_q <= (side_a[STEPS].mode == MODE_FWD) ? r_dw : lane_a[STEPS][0].x;
    m1c_q <= (side_a[STEPS].mode == MODE_FWD) ? cs_dec[63:32] : KQ30;
    m2a_q <= r_dw;
    m2c_q <= cs_dec[31:0];
  end

  // ---------------- First multiply ----------------
  dw_t   p1, p2;
  logic  valid_m [MUL_LAT];
  side_t side_m  [MUL_LAT];

  scs_mulq u_mul1 (.clk_i(clk_i), .a_i(m1a_q), .c_i(m1c_q), .p_o(p1));
  scs_mulq u_mul2 (.clk_i(clk_i), .a_i(m2a_q), .c_i(m2c_q), .p_o(p2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MUL_LAT; k++) begin
        valid_m[k] <= 1'b0;
      end
    end else begin
      valid_m[0] <= valid_q_q;
      for (int k = 1; k < MUL_LAT; k++) begin
        valid_m[k] <= valid_m[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_m[0] <= side_q_q;
    for (int k = 1; k < MUL_LAT; k++) begin
      side_m[k] <= side_m[k-1];
    end
  end

  // ---------------- Chain B: elevation and length ----------------
  logic              valid_b [STEPS+1];
  lane_t [LANES-1:0] lane_b  [STEPS+1];
  side_t             side_b  [STEPS];
  side_t             side_b_in;

  always_comb begin
    lane_b[0][0].x   = p1;
    lane_b[0][0].y   = side_m[MUL_LAT-1].zc;
    lane_b[0][0].z   = '0;
    lane_b[0][0].vec = 1'b1;
    lane_b[0][1]     = '0;
    side_b_in        = side_m[MUL_LAT-1];
    side_b_in.rc     = p1;
    side_b_in.zr     = p2;
  end

  assign valid_b[0] = valid_m[MUL_LAT-1];

  for (genvar k = 0; k < STEPS; k++) begin : g_chain_b
    scs_cell #(.STEP(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_b[k]),
      .lane_i  (lane_b[k]),
      .valid_o (valid_b[k+1]),
      .lane_o  (lane_b[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    side_b[0] <= side_b_in;
    for (int k = 1; k < STEPS; k++) begin
      side_b[k] <= side_b[k-1];
    end
  end

  // ---------------- Second multiply ----------------
  dw_t                p3, p4, m3a;
  logic signed [31:0] m3c;
  logic               valid_f [MUL_LAT];
  side_t              side_f  [MUL_LAT];
  side_t              side_f_in;

  assign m3a = (side_b[STEPS-1].mode == MODE_FWD) ? side_b[STEPS-1].rc
                                                  : lane_b[STEPS][0].x;
  assign m3c = (side_b[STEPS-1].mode == MODE_FWD) ? side_b[STEPS-1].ca : KQ30;

  scs_mulq u_mul3 (.clk_i(clk_i), .a_i(m3a), .c_i(m3c), .p_o(p3));
  scs_mulq u_mul4 (.clk_i(clk_i), .a_i(side_b[STEPS-1].rc),
                   .c_i(side_b[STEPS-1].sa), .p_o(p4));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MUL_LAT; k++) begin
        valid_f[k] <= 1'b0;
      end
    end else begin
      valid_f[0] <= valid_b[STEPS];
      for (int k = 1; k < MUL_LAT; k++) begin
        valid_f[k] <= valid_f[k-1];
      end
    end
  end

  // Attach the elevation angle to the side word
  always_comb begin
    side_f_in   = side_b[STEPS-1];
    side_f_in.d = lane_b[STEPS][0].z;
  end

  always_ff @(posedge clk_i) begin
    side_f[0] <= side_f_in;
    for (int k = 1; k < MUL_LAT; k++) begin
      side_f[k] <= side_f[k-1];
    end
  end

  // ---------------- Output stage ----------------
  scs_res_t      res_d;
  side_t         sf;
  logic [DW-1:0] rng_pos, rng_sh;
  dw_t           ang, dec;

  assign sf      = side_f[MUL_LAT-1];
  assign rng_pos = p3[DW-1] ? '0 : DW'(p3);
  assign rng_sh  = (rng_pos + RND_G) >> GUARD;

  // Saturate coordinates forward; clamp and convert angles, round and saturate range inverse
  always_comb begin
    res_d = '0;
    ang   = sf.xy_zero ? '0 : sf.ang_a;
    dec   = sf.xyz_zero ? '0 : sf.d;
    if (dec > ONE_Q30) begin
      dec = ONE_Q30;
    end else if (dec < -ONE_Q30) begin
      dec = -ONE_Q30;
    end
    if (sf.mode == MODE_FWD) begin
      res_d.x_out = sat_coord(p3);
      res_d.y_out = sat_coord(p4);
      res_d.z_out = sat_coord(sf.zr);
    end else begin
      res_d.ra_out  = from_turns(ang);
      res_d.dec_out = from_turns(dec);
      if (sf.xyz_zero) begin
        res_d.range_out = '0;
      end else if (rng_sh > RMAX) begin
        res_d.range_out = RMAX[COORD_BITS-1:0];
      end else begin
        res_d.range_out = rng_sh[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= valid_f[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

`ifndef SYNTHESIS
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY strobe_o)
    else $error("accepted word produced no result at the expected cycle");

  a_latency_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching accepted word");

  a_unused_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (res_o.ra_out != '0 || res_o.dec_out != '0 || res_o.range_out != '0))
    |-> (res_o.x_out == '0 && res_o.y_out == '0 && res_o.z_out == '0))
    else $error("forward and inverse result fields both nonzero");
`endif

endmodule

@@ sv/scs_cell.sv @@
// One CORDIC micro-rotation cell, two lanes, registered toward the next cell.
`timescale 1ns / 1ps

module scs_cell import scs_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  lane_t [LANES-1:0]     lane_i,
  output logic                  valid_o,
  output lane_t [LANES-1:0]     lane_o
);

  localparam dw_t ANGLE = dw_t'({{(DW-32){1'b0}}, ATAN_TURNS[STEP]});

  lane_t [LANES-1:0] lane_d;
  dw_t               shx [LANES];
  dw_t               shy [LANES];
  logic              plus [LANES];

  // Rotate toward zero angle (rotation) or toward the x axis (vectoring)
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      shx[l]  = lane_i[l].x >>> STEP;
      shy[l]  = lane_i[l].y >>> STEP;
      plus[l] = lane_i[l].vec ? lane_i[l].y[DW-1] : ~lane_i[l].z[DW-1];
      lane_d[l].vec = lane_i[l].vec;
      if (plus[l]) begin
        lane_d[l].x = lane_i[l].x - shy[l];
        lane_d[l].y = lane_i[l].y + shx[l];
        lane_d[l].z = lane_i[l].z - ANGLE;
      end else begin
        lane_d[l].x = lane_i[l].x + shy[l];
        lane_d[l].y = lane_i[l].y - shx[l];
        lane_d[l].z = lane_i[l].z + ANGLE;
      end
    end
  end

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  // Hand the lanes to the next cell
  always_ff @(posedge clk_i) begin
    lane_o <= lane_d;
  end

endmodule

@@ sv/scs_mulq.sv @@
// Three-stage Q30 multiplier, result rounded with ties away from zero.
`timescale 1ns / 1ps

module scs_mulq import scs_pkg::*; (
  input  logic               clk_i,
  input  dw_t                a_i,
  input  logic signed [31:0] c_i,
  output dw_t                p_o
);

  localparam logic [DW-1:0] RND29 = DW'(64'd1 << 29);

  logic          neg1_q, neg2_q;
  logic [DW-1:0] ua_q;
  logic [30:0]   uc_q;
  logic [62:0]   phi_q, plo_q;
  logic [31:0]   uc_full;
  logic [DW-1:0] r_sum;

  assign uc_full = c_i[31] ? 32'(-c_i) : 32'(c_i);

  // Take magnitudes and the product sign
  always_ff @(posedge clk_i) begin
    neg1_q <= a_i[DW-1] ^ c_i[31];
    ua_q   <= a_i[DW-1] ? DW'(-a_i) : DW'(a_i);
    uc_q   <= uc_full[30:0];
  end

  // Form high and low partial products
  always_ff @(posedge clk_i) begin
    neg2_q <= neg1_q;
    phi_q  <= ua_q[DW-1:32] * uc_q;
    plo_q  <= ua_q[31:0] * uc_q;
  end

  // Combine, round and restore the sign
  assign r_sum = {phi_q[61:0], 2'b00} + ((DW'(plo_q) + RND29) >> 30);

  always_ff @(posedge clk_i) begin
    p_o <= neg2_q ? dw_t'(-r_sum) : dw_t'(r_sum);
  end

endmodule
